FILE: design/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the fixed-point alu
// operation codes, status codes and the command/result word structs
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int W              = DATA_WIDTH_DEF;

    typedef enum logic [3:0] {
        FN_ADD    = 4'd0,
        FN_SUB    = 4'd1,
        FN_MUL    = 4'd2,
        FN_DIV    = 4'd3,
        FN_GT     = 4'd4,
        FN_LT     = 4'd5,
        FN_GE     = 4'd6,
        FN_LE     = 4'd7,
        FN_EQ     = 4'd8,
        FN_NE     = 4'd9,
        FN_TO_INT = 4'd10
    } t_func;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic [3:0]          func;
        logic signed [W-1:0] operand_a;
        logic signed [W-1:0] operand_b;
    } t_cmd;

    typedef struct packed {
        logic signed [W-1:0] result;
        logic [1:0]          status;
    } t_res;

endpackage

FILE: design/fpa_div_stage.sv
// ----------------------------------------------------------------------------
// fpa_div_stage: one restoring division step stage
// shifts one dividend bit into the remainder and takes one quotient bit
// ----------------------------------------------------------------------------
module fpa_div_stage #(
    parameter int DW = 32,
    parameter int NW = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [DW-1:0] i_rem,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_vld,
    output logic [DW-1:0] o_rem,
    output logic [NW-1:0] o_num,
    output logic [DW-1:0] o_den
);
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    assign trial = {i_rem, i_num[NW-1]};
    assign diff  = trial - {1'b0, i_den};
    assign take  = (trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_rem <= take ? diff[DW-1:0] : trial[DW-1:0];
        o_num <= {i_num[NW-2:0], take};
        o_den <= i_den;
    end
endmodule

FILE: design/fixed_point_alu_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_unit: pipelined signed fixed-point alu
// add, sub, mul, div with round-half-away and saturation, compares, to_int
// ----------------------------------------------------------------------------
// pipeline: stage 1 registers the command, then the divider stages, then the
// output register that raises o_strobe
// throughput: one word per cycle, busy stays low; pipeline depth set by the divider
// chain of one restoring step per stage
// reset: synchronous active-low i_rst_n clears all valid bits, no payload reset
// the receiver cannot stall: every result shows for exactly one cycle
module fixed_point_alu_unit #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  fpa_pkg::t_cmd  i_cmd,
    output logic           o_strobe,
    output fpa_pkg::t_res  o_res
);
    import fpa_pkg::*;

    localparam int NW   = W + FRAC_BITS;  // divider numerator width
    localparam int PW   = 2 * W;          // product width
    localparam int LAT  = NW + 2;         // accepting edge to the edge ending the strobe
    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MAXN = {1'b1, {(W-1){1'b0}}};

    assign busy = 1'b0;

    // ---------------- stage 1: magnitudes, signs, simple ops ----------------
    logic          acc;
    logic          na, nb;
    logic [W-1:0]  ma, mb;
    assign acc = start & ~busy;
    assign na  = i_cmd.operand_a[W-1];
    assign nb  = i_cmd.operand_b[W-1];
    assign ma  = na ? (~i_cmd.operand_a + 1'b1) : i_cmd.operand_a;
    assign mb  = nb ? (~i_cmd.operand_b + 1'b1) : i_cmd.operand_b;

    logic          r_v1;
    logic [3:0]    r_fn1;
    logic          r_neg1;
    logic          r_na1;
    logic [W-1:0]  r_ma1, r_mb1;
    logic [W-1:0]  r_simple1;   // add/sub/compare/to_int result
    logic [1:0]    r_sst1;
    logic [W-1:0]  n_simple;
    logic [1:0]    n_sst;
    logic [W:0]    sum;

    always_comb begin
        n_simple = '0;
        n_sst    = ST_OK;
        sum      = '0;
        case (i_cmd.func)
            FN_ADD, FN_SUB: begin
                if (i_cmd.func == FN_ADD)
                    sum = {na, i_cmd.operand_a} + {nb, i_cmd.operand_b};
                else
                    sum = {na, i_cmd.operand_a} - {nb, i_cmd.operand_b};
                if (sum[W] != sum[W-1]) begin
                    n_simple = sum[W] ? MAXN : MAXP;
                    n_sst    = ST_OVF;
                end else begin
                    n_simple = sum[W-1:0];
                end
            end
            FN_GT: n_simple = W'(i_cmd.operand_a > i_cmd.operand_b);
            FN_LT: n_simple = W'(i_cmd.operand_a < i_cmd.operand_b);
            FN_GE: n_simple = W'(i_cmd.operand_a >= i_cmd.operand_b);
            FN_LE: n_simple = W'(i_cmd.operand_a <= i_cmd.operand_b);
            FN_EQ: n_simple = W'(i_cmd.operand_a == i_cmd.operand_b);
            FN_NE: n_simple = W'(i_cmd.operand_a != i_cmd.operand_b);
            FN_TO_INT: n_simple = W'(i_cmd.operand_a >>> FRAC_BITS);
            default: n_simple = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= acc;
        end
        r_fn1     <= i_cmd.func;
        r_neg1    <= na ^ nb;
        r_na1     <= na;
        r_ma1     <= ma;
        r_mb1     <= mb;
        r_simple1 <= n_simple;
        r_sst1    <= n_sst;
    end

    // ---------------- multiply path: 16x16 partial products ----------------
    localparam int HW = W / 2;
    logic [W-1:0]  a_lo, a_hi, b_lo, b_hi;
    logic [PW-1:0] r_pll, r_plh, r_phl, r_phh;
    logic [PW-1:0] r_prod;
    // operand halves zero-extended so each partial product keeps all its bits
    assign a_lo = {{(W-HW){1'b0}}, r_ma1[HW-1:0]};
    assign a_hi = {{HW{1'b0}}, r_ma1[W-1:HW]};
    assign b_lo = {{(W-HW){1'b0}}, r_mb1[HW-1:0]};
    assign b_hi = {{HW{1'b0}}, r_mb1[W-1:HW]};
    always_ff @(posedge i_clk) begin
        r_pll  <= PW'(a_lo * b_lo);
        r_plh  <= PW'(a_lo * b_hi) << HW;
        r_phl  <= PW'(a_hi * b_lo) << HW;
        r_phh  <= PW'(a_hi * b_hi) << W;
        r_prod <= r_pll + r_plh + r_phl + r_phh;
    end
    // rounded, shifted magnitude of the product, registered
    logic [PW:0]   rnd;
    logic [PW:0]   r_pmag;
    assign rnd = {1'b0, r_prod}
               + ((PW + 1)'(FRAC_BITS > 0) << (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0));
    always_ff @(posedge i_clk) begin
        r_pmag <= rnd >> FRAC_BITS;
    end

    // ---------------- divide path: NW restoring stages ----------------
    logic [NW:0]         dv;
    logic [NW:0][W-1:0]  drem;
    logic [NW:0][NW-1:0] dnum;
    logic [NW:0][W-1:0]  dden;
    assign dv[0]   = r_v1;
    assign drem[0] = '0;
    assign dnum[0] = NW'(r_ma1) << FRAC_BITS;
    assign dden[0] = r_mb1;

    for (genvar g = 0; g < NW; g++) begin : g_div
        fpa_div_stage #(.DW(W), .NW(NW)) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (dv[g]),
            .i_rem  (drem[g]),
            .i_num  (dnum[g]),
            .i_den  (dden[g]),
            .o_vld  (dv[g+1]),
            .o_rem  (drem[g+1]),
            .o_num  (dnum[g+1]),
            .o_den  (dden[g+1])
        );
    end

    // ---------------- side-band delay line for control and simple results ----
    typedef struct packed {
        logic [3:0]   fn;
        logic         neg;
        logic         na;
        logic         bz;
        logic [W-1:0] simple;
        logic [1:0]   sst;
    } t_side;

    t_side r_side [NW];
    t_side s_in;
    assign s_in = '{fn: r_fn1, neg: r_neg1, na: r_na1, bz: (r_mb1 == '0),
                    simple: r_simple1, sst: r_sst1};
    always_ff @(posedge i_clk) begin
        r_side[0] <= s_in;
        for (int k = 1; k < NW; k++) r_side[k] <= r_side[k-1];
    end

    // product magnitude delay to line up with the divider output
    // product goes through partial-product, sum and rounding registers, divider through NW stages
    logic [PW:0] r_pd [NW-3];
    always_ff @(posedge i_clk) begin
        r_pd[0] <= r_pmag;
        for (int k = 1; k < NW - 3; k++) r_pd[k] <= r_pd[k-1];
    end

    // ---------------- final stage: rounding, saturation, select ----------------
    t_side         sf;
    logic [PW:0]   pm;
    logic [NW:0]   qm;
    logic [PW:0]   mag;
    logic [W-1:0]  lim;
    logic          rup;
    t_res          n_res;
    assign sf  = r_side[NW-1];
    assign pm  = r_pd[NW-4];
    // round when remainder >= den - remainder
    assign rup = ({1'b0, drem[NW]} << 1) >= {1'b0, dden[NW]};
    assign qm  = {1'b0, dnum[NW]} + (NW + 1)'(rup);

    always_comb begin
        n_res = '{result: sf.simple, status: sf.sst};
        lim   = sf.neg ? MAXN : MAXP;
        mag   = '0;
        if (sf.fn == FN_MUL || sf.fn == FN_DIV) begin
            mag = (sf.fn == FN_MUL) ? pm : (PW + 1)'(qm);
            if (sf.fn == FN_DIV && sf.bz) begin
                n_res.result = sf.na ? MAXN : MAXP;
                n_res.status = ST_DIV0;
            end else if (mag > (PW + 1)'(lim)) begin
                n_res.result = lim;
                n_res.status = ST_OVF;
            end else begin
                n_res.result = sf.neg ? (~mag[W-1:0] + 1'b1) : mag[W-1:0];
                n_res.status = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= dv[NW];
        end
        o_res <= n_res;
    end

    // ---------------- checks ----------------
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##LAT o_strobe)
        else $error("result strobe missing after command");
    a_noinv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(acc, LAT))
        else $error("result strobe without command");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_res.status == ST_OK || o_res.status == ST_OVF
                      || o_res.status == ST_DIV0))
        else $error("bad status code");
endmodule

FILE: bench/fixed_point_alu_unit_test.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_unit_test: self-checking bench for the fixed-point alu
// a directed table, then random words, are checked against an exact
// integer predictor; results come out in order, one per command
// ----------------------------------------------------------------------------
module fixed_point_alu_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fpa_pkg::*;

    localparam int FB        = FRAC_BITS_DEF;
    localparam int LATENCY   = W + FB + 3;
    localparam int WDOG_MAX  = 20 * LATENCY + 2000;
    localparam int N_RANDOM  = 1330;
    localparam logic signed [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    logic o_strobe;
    t_res o_res;

    fixed_point_alu_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .o_strobe(o_strobe), .o_res(o_res)
    );

    // results still owed by the alu, oldest first
    t_res pending_results[$];
    int   n_errors;
    int   n_checked;
    int   idle_cycles;
    int   sender_idle_pct;
    bit   timed_out;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        n_errors++;
    endtask

    // saturate a sign/magnitude value into a word
    function automatic t_res saturate_word(input bit neg, input logic [127:0] mag);
        t_res r;
        logic [127:0] lim;
        lim = neg ? 128'(MIN_W) & {{(128-W){1'b0}}, {W{1'b1}}} : 128'(MAX_W);
        r.status = ST_OK;
        if (mag > lim) begin
            mag = lim;
            r.status = ST_OVF;
        end
        r.result = neg ? W'(-mag) : W'(mag);
        return r;
    endfunction

    // exact fixed-point result of one command
    function automatic t_res alu_predict(input t_cmd c);
        t_res r;
        logic signed [W:0] s;
        logic [127:0] ma, mb, p, q, rem;
        bit neg;
        r.result = '0;
        r.status = ST_OK;
        ma = c.operand_a[W-1] ? 128'(-(129'(c.operand_a))) : 128'(c.operand_a);
        mb = c.operand_b[W-1] ? 128'(-(129'(c.operand_b))) : 128'(c.operand_b);
        ma = ma & {{(128-W-1){1'b0}}, {(W+1){1'b1}}};
        mb = mb & {{(128-W-1){1'b0}}, {(W+1){1'b1}}};
        neg = c.operand_a[W-1] ^ c.operand_b[W-1];
        case (c.func)
            FN_ADD, FN_SUB: begin
                s = (c.func == FN_ADD) ? c.operand_a + c.operand_b
                                       : c.operand_a - c.operand_b;
                if (s > MAX_W) begin
                    r.result = MAX_W;
                    r.status = ST_OVF;
                end else if (s < MIN_W) begin
                    r.result = MIN_W;
                    r.status = ST_OVF;
                end else begin
                    r.result = s[W-1:0];
                end
            end
            FN_MUL: begin
                p = ma * mb;
                if (FB > 0) p = p + (128'(1) << (FB - 1));
                r = saturate_word(neg, p >> FB);
            end
            FN_DIV: begin
                if (mb == 0) begin
                    r.result = c.operand_a[W-1] ? MIN_W : MAX_W;
                    r.status = ST_DIV0;
                end else begin
                    q = (ma << FB) / mb;
                    rem = (ma << FB) % mb;
                    if (rem >= mb - rem) q = q + 1;
                    r = saturate_word(neg, q);
                end
            end
            FN_GT: r.result = W'(c.operand_a > c.operand_b);
            FN_LT: r.result = W'(c.operand_a < c.operand_b);
            FN_GE: r.result = W'(c.operand_a >= c.operand_b);
            FN_LE: r.result = W'(c.operand_a <= c.operand_b);
            FN_EQ: r.result = W'(c.operand_a == c.operand_b);
            FN_NE: r.result = W'(c.operand_a != c.operand_b);
            FN_TO_INT: r.result = c.operand_a >>> FB;
            default: r.result = '0;
        endcase
        return r;
    endfunction

    // result checker and idle counter for the watchdog on the sampled edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending");
                end else begin
                    t_res want;
                    want = pending_results.pop_front();
                    n_checked++;
                    if (o_res.result !== want.result)
                        report_mismatch($sformatf("result %h want %h",
                            o_res.result, want.result));
                    if (o_res.status !== want.status)
                        report_mismatch($sformatf("status %0d want %0d",
                            o_res.status, want.status));
                end
            end
            if (o_strobe || (start && !busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // one command: wait out gaps, hold start until busy is low at an edge
    task automatic issue_cmd(input t_cmd c, input bit have_expected, input t_res expected);
        t_res want;
        while (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        want = alu_predict(c);
        if (have_expected && want !== expected)
            report_mismatch($sformatf("table row func %0d disagrees with predictor",
                c.func));
        pending_results.push_back(have_expected ? expected : want);
    endtask

    function automatic logic [W-1:0] rand_operand();
        case ($urandom_range(5, 0))
            0: return MAX_W - W'($urandom_range(3, 0));
            1: return MIN_W + W'($urandom_range(3, 0));
            2: return W'($signed($urandom_range(2047, 0)) - 1024);
            3: return W'($urandom) >>> $urandom_range(W - 1, 0);
            default: return W'($urandom);
        endcase
    endfunction

    // directed table: func, a, b, typed expectation where obvious
    typedef struct {
        logic [3:0]   func;
        logic [W-1:0] a;
        logic [W-1:0] b;
        bit           typed;
        t_res         res;
    } t_row;

    t_row directed[$];

    initial begin
        t_cmd c;
        t_res none;
        n_errors = 0;
        n_checked = 0;
        idle_cycles = 0;
        timed_out = 0;
        sender_idle_pct = 0;
        none = '0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cmd <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{
            '{FN_ADD, MAX_W, 32'd1, 1, '{MAX_W, ST_OVF}},
            '{FN_ADD, MIN_W, -32'sd1, 1, '{MIN_W, ST_OVF}},
            '{FN_SUB, MIN_W, 32'd1, 1, '{MIN_W, ST_OVF}},
            '{FN_SUB, 32'd0, MIN_W, 1, '{MAX_W, ST_OVF}},
            '{FN_ADD, 32'd256, 32'd256, 1, '{32'd512, ST_OK}},
            '{FN_MUL, MAX_W, MAX_W, 1, '{MAX_W, ST_OVF}},
            '{FN_MUL, MIN_W, MAX_W, 1, '{MIN_W, ST_OVF}},
            '{FN_MUL, MIN_W, MIN_W, 1, '{MAX_W, ST_OVF}},
            '{FN_MUL, 32'd384, 32'd256, 1, '{32'd384, ST_OK}},
            '{FN_MUL, 32'd1, 32'd128, 0, none},          // tie rounds away
            '{FN_MUL, -32'sd1, 32'd128, 0, none},
            '{FN_DIV, 32'd5, 32'd0, 1, '{MAX_W, ST_DIV0}},
            '{FN_DIV, 32'd0, 32'd0, 1, '{MAX_W, ST_DIV0}},
            '{FN_DIV, -32'sd5, 32'd0, 1, '{MIN_W, ST_DIV0}},
            '{FN_DIV, MIN_W, 32'd1, 1, '{MIN_W, ST_OVF}},
            '{FN_DIV, MIN_W, -32'sd256, 1, '{MAX_W, ST_OVF}},
            '{FN_DIV, 32'd1, 32'd512, 0, none},          // half tie
            '{FN_DIV, -32'sd1, MIN_W, 0, none},
            '{FN_GT, MAX_W, MIN_W, 1, '{32'd1, ST_OK}},
            '{FN_LT, MAX_W, MIN_W, 1, '{32'd0, ST_OK}},
            '{FN_GE, MIN_W, MIN_W, 1, '{32'd1, ST_OK}},
            '{FN_LE, MAX_W, MIN_W, 1, '{32'd0, ST_OK}},
            '{FN_EQ, MIN_W, MIN_W, 1, '{32'd1, ST_OK}},
            '{FN_NE, MIN_W, MAX_W, 1, '{32'd1, ST_OK}},
            '{FN_TO_INT, -32'sd1, MAX_W, 1, '{-32'sd1, ST_OK}},
            '{4'd15, MAX_W, MIN_W, 1, '{32'd0, ST_OK}}   // unused code
        };
        foreach (directed[i]) begin
            c.func = directed[i].func;
            c.operand_a = directed[i].a;
            c.operand_b = directed[i].b;
            issue_cmd(c, directed[i].typed, directed[i].res);
        end

        // random words in four phases of sender pacing
        for (int n = 0; n < N_RANDOM; n++) begin
            case (n * 4 / N_RANDOM)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 53;
                2: sender_idle_pct = 0;
                default: sender_idle_pct = 12;
            endcase
            c.func = ($urandom_range(19, 0) == 0) ? 4'($urandom_range(15, 11))
                                                  : 4'($urandom_range(10, 0));
            c.operand_a = rand_operand();
            c.operand_b = ($urandom_range(15, 0) == 0) ? '0 : rand_operand();
            if ($urandom_range(7, 0) == 0) c.operand_b = c.operand_a;
            issue_cmd(c, 0, none);
        end
        start <= 1'b0;

        while (pending_results.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("covered %0d commands over all eleven ops plus unused codes", N_RANDOM + 26);
        $display("with saturation, divide-by-zero and rounding ties; %0d results checked",
            n_checked);
        if (n_errors == 0 && pending_results.size() == 0 && !timed_out)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog: too long with nothing accepted on either side
    always @(posedge i_clk) begin
        if (idle_cycles >= WDOG_MAX && !timed_out) begin
            timed_out = 1;
            $display("watchdog expired with %0d results pending", pending_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

FILE: files.f
design/fpa_pkg.sv
design/fpa_div_stage.sv
design/fixed_point_alu_unit.sv
bench/fixed_point_alu_unit_test.sv
